// ===== rtl/gmas_pkg.sv =====
// Package for the gap and mismatch alignment score block.
// Holds item and token types, field widths, mode and register codes and the
// saturating add. No dependencies.
`default_nettype none

package gmas_pkg;

   // Field widths of the item, the result and the penalty registers.
   localparam int SCORE_W     = 17;
   localparam int SYM_W       = 8;
   localparam int PEN_W       = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 1;
   // Length field of a token, wide enough for the largest supported string.
   localparam int LEN_FIELD_W = 13;

   // Default longest first string.
   localparam int MAX_LEN_DEF = 256;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   // Input modes.
   localparam logic [MODE_W-1:0] MODE_LOAD_X = 2'd0;
   localparam logic [MODE_W-1:0] MODE_Y_SYM  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EMIT   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAP      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH = 1'd1;

   localparam logic [PEN_W-1:0] GAP_RESET      = 8'd2;
   localparam logic [PEN_W-1:0] MISMATCH_RESET = 8'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SYM_W-1:0]  symbol;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               overflow;
   } rsp_type;

   // Kind of work a token does as it passes along the row of cells.
   typedef enum logic [1:0] {
      TK_NONE    = 2'd0,
      TK_YSYM    = 2'd1,
      TK_RESTART = 2'd2,
      TK_EMIT    = 2'd3
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type           kind;
      logic                   wr;     // restart also stores an x symbol
      logic [SYM_W-1:0]       sym;
      logic [LEN_FIELD_W-1:0] len;    // x length when the item was accepted
      logic [PEN_W-1:0]       gap;
      logic [PEN_W-1:0]       mis;
      logic [SCORE_W-1:0]     diag;
      logic [SCORE_W-1:0]     upper;
      logic [SCORE_W-1:0]     res;
      logic                   ovf;
   } tok_type;

   // Add a penalty to a score, clamping at the largest score.
   function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                  input logic [PEN_W-1:0]   b);
      logic [SCORE_W:0] s;
      s = {1'b0, a} + {{(SCORE_W + 1 - PEN_W){1'b0}}, b};
      return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gmas_head.sv =====
// Head of the alignment row: penalty registers, string lengths, border cell
// and token launch. Depends on gmas_pkg.
`default_nettype none

module gmas_head
   import gmas_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire req_type              req_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PEN_W-1:0]     csr_wdata,
   output      tok_type              tok_o
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int PW    = PEN_W + LEN_W;
   localparam int EW    = (PW > SCORE_W) ? PW : SCORE_W + 1;

   logic [PEN_W-1:0]   gap_ff, gap_in, mis_ff, mis_in;
   logic [LEN_W-1:0]   length_ff, length_in, count_ff, count_in, count_nx;
   logic [SCORE_W-1:0] col0_ff, col0_in, border;
   logic               dropped_ff, dropped_in, busy_ff;
   tok_type            tok_ff, tok_in;
   logic [PW-1:0]      prod;
   logic               accept;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;
   assign tok_o  = tok_ff;

   // Border cell for the next y symbol: gap penalty times the new count.
   assign count_nx = count_ff + LEN_W'(1);
   assign prod     = PW'(gap_ff) * PW'(count_nx);
   assign border   = (EW'(prod) > EW'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(prod);

   // Penalty register writes.
   always_comb begin
      gap_in = gap_ff;
      mis_in = mis_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAP:      gap_in = csr_wdata;
            CSR_MISMATCH: mis_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Item decode: update lengths and launch at most one token into the row.
   always_comb begin
      length_in  = length_ff;
      count_in   = count_ff;
      col0_in    = col0_ff;
      dropped_in = dropped_ff;
      tok_in       = '0;
      tok_in.kind  = TK_NONE;
      tok_in.sym   = req_data.symbol;
      tok_in.len   = LEN_FIELD_W'(length_ff);
      tok_in.gap   = gap_ff;
      tok_in.mis   = mis_ff;
      tok_in.res   = col0_ff;
      tok_in.ovf   = dropped_ff;
      if (accept) begin
         case (req_data.mode)
            MODE_LOAD_X: begin
               if (length_ff != LEN_W'(MAX_LEN)) begin
                  tok_in.wr = 1'b1;
                  length_in = length_ff + LEN_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               tok_in.kind = TK_RESTART;
               col0_in     = '0;
               count_in    = '0;
            end
            MODE_Y_SYM: begin
               if (count_ff == LEN_W'(MAX_LEN)) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in     = count_nx;
                  col0_in      = border;
                  tok_in.kind  = TK_YSYM;
                  tok_in.diag  = col0_ff;
                  tok_in.upper = border;
               end
            end
            MODE_EMIT: begin
               tok_in.kind = TK_EMIT;
               col0_in     = '0;
               count_in    = '0;
            end
            MODE_CLEAR: begin
               tok_in.kind = TK_RESTART;
               length_in   = '0;
               dropped_in  = 1'b0;
               col0_in     = '0;
               count_in    = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff      <= GAP_RESET;
         mis_ff      <= MISMATCH_RESET;
         length_ff   <= '0;
         count_ff    <= '0;
         col0_ff     <= '0;
         dropped_ff  <= 1'b0;
         busy_ff     <= 1'b1;
         tok_ff.kind <= TK_NONE;
      end else begin
         gap_ff     <= gap_in;
         mis_ff     <= mis_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         col0_ff    <= col0_in;
         dropped_ff <= dropped_in;
         busy_ff    <= 1'b0;
         tok_ff     <= tok_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Clearing x empties the string and the sticky flag.
   a_clear : assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == MODE_CLEAR |=> length_ff == '0 && !dropped_ff)
      else $error("clear did not empty x");

   // An accepted y symbol below the limit advances the count by one.
   a_count : assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == MODE_Y_SYM && count_ff != LEN_W'(MAX_LEN)
      |=> count_ff == $past(count_ff) + LEN_W'(1))
      else $error("y count did not advance");

   // An emit launches an emit token that restarts the column from zero.
   a_emit : assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == MODE_EMIT
      |=> tok_ff.kind == TK_EMIT && tok_ff.upper == '0 && col0_ff == '0)
      else $error("emit token not launched");

   // No token enters the row without an accepted item.
   a_idle : assert property (@(posedge clock) disable iff (reset)
      !accept |=> tok_ff.kind == TK_NONE)
      else $error("token launched without an item");

   // Lengths stay within the limit.
   a_limit : assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_W'(MAX_LEN) && count_ff <= LEN_W'(MAX_LEN))
      else $error("length beyond limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/gmas_cell.sv =====
// One cell of the alignment row: holds one x symbol and one column score
// and passes the token to its lower neighbor every cycle. Depends on gmas_pkg.
`default_nettype none

module gmas_cell
   import gmas_pkg::*;
#(
   parameter int IDX = 1
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire tok_type tok_i,
   output      tok_type tok_o
);

   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   tok_type            tok_ff, tok_in;
   logic [SCORE_W-1:0] d_mis, u_gap, l_gap, best, cell_val;

   assign tok_o = tok_ff;

   // Candidate costs: diagonal with mismatch, gap from above, gap from left.
   assign d_mis = sat_add(tok_i.diag, tok_i.mis);
   assign u_gap = sat_add(tok_i.upper, tok_i.gap);
   assign l_gap = sat_add(score_ff, tok_i.gap);

   always_comb begin
      best = d_mis;
      if (u_gap < best) best = u_gap;
      if (l_gap < best) best = l_gap;
      cell_val = (sym_ff == tok_i.sym) ? tok_i.diag : best;
   end

   // Token action at this cell.
   always_comb begin
      tok_in   = tok_i;
      score_in = score_ff;
      sym_in   = sym_ff;
      case (tok_i.kind)
         TK_YSYM: begin
            score_in     = cell_val;
            tok_in.diag  = score_ff;
            tok_in.upper = cell_val;
         end
         TK_RESTART: begin
            score_in     = u_gap;
            tok_in.upper = u_gap;
            if (tok_i.wr && tok_i.len == LEN_FIELD_W'(IDX - 1)) sym_in = tok_i.sym;
         end
         TK_EMIT: begin
            score_in     = u_gap;
            tok_in.upper = u_gap;
            if (tok_i.len == LEN_FIELD_W'(IDX)) tok_in.res = score_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      score_ff <= score_in;
      if (reset) begin
         tok_ff.kind <= TK_NONE;
      end else begin
         tok_ff <= tok_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gap_mismatch_alignment_score.sv =====
// Top level of the global alignment score block: head and row of cells.
// Depends on gmas_pkg, gmas_head and gmas_cell.
//
// Usage. An item (mode, symbol) is taken on req_data at a clock edge where
// start is high and busy is low. Mode 0 appends a symbol to x, mode 1 feeds
// one symbol of y, mode 2 requests the score, mode 3 clears x. Penalties are
// written through csr_we, csr_index and csr_wdata (gap at index 0, mismatch
// at index 1) while no item is in flight.
// Each accepted item, but a y symbol past the limit, becomes a token that
// walks down a row of MAX_LEN cells, one cell per cycle; cell i holds x
// symbol i and column score i. A y symbol updates the whole column as its
// token passes; tokens follow each other in order. Throughput: one item
// per cycle. A mode 2 result appears on rsp_data with rsp_strobe high for
// one cycle once its token has passed the head register and every cell of
// the row. Other modes give no result.
// The receiver cannot stall; results are never held.
// Reset is synchronous: penalties return to 2 and 3, x and y are empty,
// the overflow flag clears, and busy is high for the first cycle after it.
`default_nettype none

module gap_mismatch_alignment_score
   import gmas_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire req_type              req_data,
   output      logic                 rsp_strobe,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PEN_W-1:0]     csr_wdata
);

   tok_type tok_chain [0:MAX_LEN];

   gmas_head #(
      .MAX_LEN(MAX_LEN)
   ) u_head (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tok_o     (tok_chain[0])
   );

   // Row of cells, one per x position.
   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      gmas_cell #(
         .IDX(g + 1)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (tok_chain[g]),
         .tok_o (tok_chain[g + 1])
      );
   end

   // An emit token leaving the last cell carries the result.
   assign rsp_strobe        = (tok_chain[MAX_LEN].kind == TK_EMIT);
   assign rsp_data.score    = tok_chain[MAX_LEN].res;
   assign rsp_data.overflow = tok_chain[MAX_LEN].ovf;

endmodule

`default_nettype wire
